// ===== src/hcf_pkg.sv =====
// shared types and constants for the http header and chunk framer
`default_nettype none
package hcf_pkg;
  localparam int unsigned OFFSET_BITS_DEF = 16;
  localparam int unsigned SIZE_BITS_DEF = 32;
  localparam int unsigned NAME_LEN = 17;
  localparam int unsigned VAL_LEN = 7;
  localparam logic [7:0] CH_CR = 8'd13;
  localparam logic [7:0] CH_LF = 8'd10;
  localparam logic [7:0] CH_COLON = 8'h3a;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam int unsigned OUT_DATA_BITS = 120;

  typedef enum logic [2:0] {
    KIND_HEADER = 3'd0,
    KIND_END_HDR = 3'd1,
    KIND_CHUNK = 3'd2,
    KIND_LAST = 3'd3,
    KIND_MALFORMED = 3'd4
  } kind_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [15:0] first_start;
    logic [15:0] first_length;
    logic [15:0] value_begin;
    logic [15:0] value_length;
    logic [31:0] chunk_size;
    logic chunked;
    logic [15:0] index;
    logic overflow;
  } rec_t;

  function automatic logic [7:0] name_char(input logic [4:0] i);
    logic [7:0] c;
    case (i)
      5'd0: c = "t";   5'd1: c = "r";  5'd2: c = "a";  5'd3: c = "n";
      5'd4: c = "s";   5'd5: c = "f";  5'd6: c = "e";  5'd7: c = "r";
      5'd8: c = "-";   5'd9: c = "e";  5'd10: c = "n"; 5'd11: c = "c";
      5'd12: c = "o";  5'd13: c = "d"; 5'd14: c = "i"; 5'd15: c = "n";
      5'd16: c = "g";
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] val_char(input logic [2:0] i);
    logic [7:0] c;
    case (i)
      3'd0: c = "c"; 3'd1: c = "h"; 3'd2: c = "u"; 3'd3: c = "n";
      3'd4: c = "k"; 3'd5: c = "e"; 3'd6: c = "d";
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [3:0] hex_digit(input logic [7:0] b);
    logic [3:0] d;
    d = 4'd0;
    if (b >= "0" && b <= "9") d = 4'(b - "0");
    else if (b >= "A" && b <= "F") d = 4'(b - "A" + 8'd10);
    else if (b >= "a" && b <= "f") d = 4'(b - "a" + 8'd10);
    return d;
  endfunction
endpackage
`default_nettype wire

// ===== src/hcf_parser.sv =====
// front part: byte classifier and parse state machine, one byte per step
`default_nettype none
module hcf_parser #(
  parameter int unsigned OFFSET_BITS = hcf_pkg::OFFSET_BITS_DEF,
  parameter int unsigned SIZE_BITS = hcf_pkg::SIZE_BITS_DEF
) (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic step,
  input wire logic msg_start,
  input wire logic [7:0] b,
  output hcf_pkg::rec_t rec,
  output logic rec_valid
);
  typedef enum logic [3:0] {
    PH_LEAD, PH_LINE, PH_KEY, PH_KEY_CR, PH_VSKIP, PH_VALUE, PH_VALUE_CR,
    PH_BLANK_CR, PH_CLEAD, PH_SIZE, PH_SIZE_CR, PH_DATA, PH_TRAIL1,
    PH_TRAIL2, PH_DONE
  } phase_t;

  localparam logic [OFFSET_BITS-1:0] OFS_MAX = '1;

  phase_t ph_r, ph_nxt;
  logic [OFFSET_BITS-1:0] pos_r, pos_nxt, ko_r, ko_nxt, ks_r, ks_nxt, vo_r, vo_nxt;
  logic [4:0] nm_r, nm_nxt;
  logic ns_r, ns_nxt;
  logic [2:0] vm_r, vm_nxt;
  logic es_r, es_nxt, ck_r, ck_nxt, va_r, va_nxt, sat_r, sat_nxt;
  logic [SIZE_BITS-1:0] hex_r, hex_nxt, rem_r, rem_nxt;
  logic [15:0] hc_r, hc_nxt, cc_r, cc_nxt;

  logic [OFFSET_BITS-1:0] pos, prev, npos;
  logic sat_now;

  always_comb begin
    phase_t ph;
    logic [7:0] lc, lcr;
    ph = ph_r; pos = pos_r; ko_nxt = ko_r; ks_nxt = ks_r; vo_nxt = vo_r;
    nm_nxt = nm_r; ns_nxt = ns_r; vm_nxt = vm_r; es_nxt = es_r; ck_nxt = ck_r;
    va_nxt = va_r; sat_now = sat_r; hex_nxt = hex_r; rem_nxt = rem_r;
    hc_nxt = hc_r; cc_nxt = cc_r;
    if (msg_start) begin
      ph = PH_LEAD; pos = '0; ko_nxt = '0; ks_nxt = '0; vo_nxt = '0;
      nm_nxt = '0; ns_nxt = 1'b1; vm_nxt = '0; es_nxt = 1'b0; ck_nxt = 1'b0;
      va_nxt = 1'b0; sat_now = 1'b0; hex_nxt = '0; rem_nxt = '0;
      hc_nxt = '0; cc_nxt = '0;
    end
    prev = (pos != '0) ? pos - 1'b1 : '0;
    npos = (pos != OFS_MAX) ? pos + 1'b1 : OFS_MAX;
    if (pos == OFS_MAX) sat_now = 1'b1;
    ph_nxt = ph;
    rec = '0;
    rec.overflow = sat_now;
    rec_valid = 1'b0;
    lc = (b >= "A" && b <= "Z") ? b + 8'd32 : b;
    lcr = hcf_pkg::CH_CR;

    // carry pending cr into key or value or size, and restart keys
    if (ph == PH_KEY_CR && b != hcf_pkg::CH_LF) begin
      if (ns_nxt && nm_nxt < 5'(hcf_pkg::NAME_LEN) && lcr == hcf_pkg::name_char(nm_nxt))
        nm_nxt = nm_nxt + 1'b1;
      else ns_nxt = 1'b0;
      ph = PH_KEY;
    end
    if (ph == PH_BLANK_CR && b != hcf_pkg::CH_LF) begin
      ko_nxt = prev; nm_nxt = '0; ns_nxt = 1'b0; ph = PH_KEY;
    end
    if ((ph == PH_LEAD && b != hcf_pkg::CH_CR && b != hcf_pkg::CH_LF) ||
        (ph == PH_LINE && b != hcf_pkg::CH_CR)) begin
      ko_nxt = pos; nm_nxt = '0; ns_nxt = 1'b1; ph = PH_KEY;
    end
    if (ph == PH_VALUE_CR && b != hcf_pkg::CH_LF) begin
      if (va_nxt) begin
        if (vm_nxt < 3'(hcf_pkg::VAL_LEN) && lcr == hcf_pkg::val_char(vm_nxt)) begin
          vm_nxt = vm_nxt + 1'b1;
          if (vm_nxt == 3'(hcf_pkg::VAL_LEN)) begin ck_nxt = 1'b1; va_nxt = 1'b0; end
        end else va_nxt = 1'b0;
      end
      ph = PH_VALUE;
    end
    if (ph == PH_SIZE_CR && b != hcf_pkg::CH_LF) begin
      hex_nxt = hex_nxt << 4;
      ph = PH_SIZE;
    end
    ph_nxt = ph;

    case (ph)
      PH_LEAD, PH_LINE: begin
        if (ph == PH_LINE) ph_nxt = PH_BLANK_CR;
      end
      PH_KEY: begin
        if (b == hcf_pkg::CH_COLON) begin
          ks_nxt = (pos > ko_nxt) ? pos - ko_nxt : '0;
          if (ns_nxt && nm_nxt == 5'(hcf_pkg::NAME_LEN) && !es_nxt) begin
            es_nxt = 1'b1; va_nxt = 1'b1; vm_nxt = '0;
          end
          ph_nxt = PH_VSKIP;
        end else if (b == hcf_pkg::CH_CR) begin
          ph_nxt = PH_KEY_CR;
        end else if (ns_nxt && nm_nxt < 5'(hcf_pkg::NAME_LEN) &&
                     lc == hcf_pkg::name_char(nm_nxt)) begin
          nm_nxt = nm_nxt + 1'b1;
        end else ns_nxt = 1'b0;
      end
      PH_KEY_CR: begin
        rec.kind = hcf_pkg::KIND_MALFORMED;
        rec.first_start = 16'(ko_nxt);
        rec.index = hc_nxt;
        rec_valid = 1'b1;
        ph_nxt = PH_LINE;
      end
      PH_VSKIP, PH_VALUE: begin
        if (ph == PH_VSKIP && b > hcf_pkg::CH_SPACE) begin
          vo_nxt = pos; ph_nxt = PH_VALUE;
        end
        if (ph == PH_VALUE && b == hcf_pkg::CH_CR) ph_nxt = PH_VALUE_CR;
        else if (ph_nxt == PH_VALUE && va_nxt) begin
          if (vm_nxt < 3'(hcf_pkg::VAL_LEN) && b == hcf_pkg::val_char(vm_nxt)) begin
            vm_nxt = vm_nxt + 1'b1;
            if (vm_nxt == 3'(hcf_pkg::VAL_LEN)) begin ck_nxt = 1'b1; va_nxt = 1'b0; end
          end else va_nxt = 1'b0;
        end
      end
      PH_VALUE_CR: begin
        rec.kind = hcf_pkg::KIND_HEADER;
        rec.first_start = 16'(ko_nxt);
        rec.first_length = 16'(ks_nxt);
        rec.value_begin = 16'(vo_nxt);
        rec.value_length = 16'((prev > vo_nxt) ? prev - vo_nxt : '0);
        rec.index = hc_nxt;
        rec_valid = 1'b1;
        if (hc_nxt != 16'hffff) hc_nxt = hc_nxt + 1'b1;
        va_nxt = 1'b0;
        ph_nxt = PH_LINE;
      end
      PH_BLANK_CR: begin
        rec.kind = hcf_pkg::KIND_END_HDR;
        rec.first_start = 16'(npos);
        rec.chunked = ck_nxt;
        rec.index = hc_nxt;
        rec_valid = 1'b1;
        ph_nxt = ck_nxt ? PH_CLEAD : PH_DONE;
      end
      PH_CLEAD, PH_SIZE: begin
        if (ph == PH_CLEAD && b != hcf_pkg::CH_CR && b != hcf_pkg::CH_LF) begin
          hex_nxt = SIZE_BITS'({hcf_pkg::hex_digit(b)});
          ph_nxt = PH_SIZE;
        end else if (ph == PH_SIZE) begin
          if (b == hcf_pkg::CH_CR) ph_nxt = PH_SIZE_CR;
          else hex_nxt = (hex_nxt << 4) | SIZE_BITS'(hcf_pkg::hex_digit(b));
        end
      end
      PH_SIZE_CR: begin
        rec_valid = 1'b1;
        rec.index = cc_nxt;
        if (hex_nxt == '0) begin
          rec.kind = hcf_pkg::KIND_LAST;
          ph_nxt = PH_DONE;
        end else begin
          rec.kind = hcf_pkg::KIND_CHUNK;
          rec.first_start = 16'(npos);
          rec.chunk_size = 32'(hex_nxt);
          if (cc_nxt != 16'hffff) cc_nxt = cc_nxt + 1'b1;
          rem_nxt = hex_nxt;
          ph_nxt = PH_DATA;
        end
      end
      PH_DATA: begin
        if (rem_nxt != '0) rem_nxt = rem_nxt - 1'b1;
        if (rem_nxt == '0) ph_nxt = PH_TRAIL1;
      end
      PH_TRAIL1: ph_nxt = PH_TRAIL2;
      PH_TRAIL2: ph_nxt = PH_CLEAD;
      default: ph_nxt = PH_DONE;
    endcase
    pos_nxt = npos;
    sat_nxt = sat_now;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r <= PH_LEAD; pos_r <= '0; ko_r <= '0; ks_r <= '0; vo_r <= '0;
      nm_r <= '0; ns_r <= 1'b1; vm_r <= '0; es_r <= 1'b0; ck_r <= 1'b0;
      va_r <= 1'b0; sat_r <= 1'b0; hex_r <= '0; rem_r <= '0;
      hc_r <= '0; cc_r <= '0;
    end else if (step) begin
      ph_r <= ph_nxt; pos_r <= pos_nxt; ko_r <= ko_nxt; ks_r <= ks_nxt;
      vo_r <= vo_nxt; nm_r <= nm_nxt; ns_r <= ns_nxt; vm_r <= vm_nxt;
      es_r <= es_nxt; ck_r <= ck_nxt; va_r <= va_nxt; sat_r <= sat_nxt;
      hex_r <= hex_nxt; rem_r <= rem_nxt; hc_r <= hc_nxt; cc_r <= cc_nxt;
    end
  end

  property p_pos_sat;
    @(posedge clk) disable iff (!rst_n)
      (step && !msg_start && pos_r == OFS_MAX) |=> pos_r == OFS_MAX;
  endproperty
  a_pos_sat: assert property (p_pos_sat) else $error("offset left saturation");

  property p_sat_flag;
    @(posedge clk) disable iff (!rst_n) (pos_r == OFS_MAX && step && !msg_start) |=> sat_r;
  endproperty
  a_sat_flag: assert property (p_sat_flag) else $error("saturation flag missing");

  property p_chunked_seen;
    @(posedge clk) disable iff (!rst_n) ck_r |-> es_r;
  endproperty
  a_chunked_seen: assert property (p_chunked_seen) else $error("chunked without header");
endmodule
`default_nettype wire

// ===== src/hcf_queue.sv =====
// short record queue between the parser and the output stage
`default_nettype none
module hcf_queue (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic wr_en,
  input wire hcf_pkg::rec_t wr_data,
  output logic full,
  input wire logic rd_en,
  output hcf_pkg::rec_t rd_data,
  output logic empty
);
  hcf_pkg::rec_t mem [4];
  logic [1:0] wp_r, rp_r;
  logic [2:0] cnt_r;

  assign full = (cnt_r == 3'd4);
  assign empty = (cnt_r == 3'd0);
  assign rd_data = mem[rp_r];

  always_ff @(posedge clk) begin
    if (wr_en) mem[wp_r] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; cnt_r <= '0;
    end else begin
      if (wr_en) wp_r <= wp_r + 1'b1;
      if (rd_en) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + 3'(wr_en) - 3'(rd_en);
    end
  end

  property p_no_overrun;
    @(posedge clk) disable iff (!rst_n) full |-> !wr_en || rd_en;
  endproperty
  a_no_overrun: assert property (p_no_overrun) else $error("queue overrun");

  property p_no_underrun;
    @(posedge clk) disable iff (!rst_n) empty |-> !rd_en;
  endproperty
  a_no_underrun: assert property (p_no_underrun) else $error("queue underrun");
endmodule
`default_nettype wire

// ===== src/http_header_and_chunk_framer_unit.sv =====
// top level of the http header and chunk framer
//  channel | dir | tdata fields (low bit up)
//  in_     | in  | data_byte; tuser = message_start
//  out_    | out | first_start, first_length, value_begin, value_length,
//          |     | chunk_size, body_is_chunked, record_index, offset_overflow;
//          |     | tuser = record_kind
// one byte per cycle through the parse state machine while the queue is not full
// records wait in a four-entry queue; in_tready drops only when it is full
// the output register is refilled in the cycle it is taken, if a record is waiting
// synchronous active-low reset; no clearing pass
`default_nettype none
module http_header_and_chunk_framer_unit #(
  parameter int unsigned OFFSET_BITS = hcf_pkg::OFFSET_BITS_DEF,
  parameter int unsigned SIZE_BITS = hcf_pkg::SIZE_BITS_DEF
) (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_tvalid,
  output logic in_tready,
  input wire logic [7:0] in_tdata,   // data_byte
  input wire logic in_tuser,         // message_start
  output logic out_tvalid,
  input wire logic out_tready,
  output logic [119:0] out_tdata,    // first_start, first_length, value_begin,
                                     // value_length, chunk_size, body_is_chunked,
                                     // record_index, offset_overflow, pad
  output logic [2:0] out_tuser       // record_kind
);
  hcf_pkg::rec_t rec, q_rd;
  logic rec_valid, q_full, q_empty, step, q_rd_en;
  logic ov_r;
  hcf_pkg::rec_t ob_r;

  assign in_tready = !q_full;
  assign step = in_tvalid && in_tready;

  hcf_parser #(.OFFSET_BITS(OFFSET_BITS), .SIZE_BITS(SIZE_BITS)) u_parser (
    .clk(clk), .rst_n(rst_n), .step(step), .msg_start(in_tuser), .b(in_tdata),
    .rec(rec), .rec_valid(rec_valid)
  );

  hcf_queue u_queue (
    .clk(clk), .rst_n(rst_n), .wr_en(step && rec_valid), .wr_data(rec),
    .full(q_full), .rd_en(q_rd_en), .rd_data(q_rd), .empty(q_empty)
  );

  assign q_rd_en = !q_empty && (!ov_r || out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (q_rd_en) begin
      ov_r <= 1'b1;
    end else if (out_tready) begin
      ov_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_rd_en) ob_r <= q_rd;
  end

  assign out_tvalid = ov_r;
  assign out_tuser = ob_r.kind;
  assign out_tdata = {6'd0, ob_r.overflow, ob_r.index, ob_r.chunked, ob_r.chunk_size,
                      ob_r.value_length, ob_r.value_begin, ob_r.first_length,
                      ob_r.first_start};

  property p_hold;
    @(posedge clk) disable iff (!rst_n) (out_tvalid && !out_tready) |=> $stable(out_tdata);
  endproperty
  a_hold: assert property (p_hold) else $error("output changed while stalled");

  property p_kind;
    @(posedge clk) disable iff (!rst_n) out_tvalid |-> out_tuser <= 3'd4;
  endproperty
  a_kind: assert property (p_kind) else $error("bad record kind");
endmodule
`default_nettype wire
